// ----- src/psaf_pkg.sv -----
// Package: types, state codes and helpers for the particle step block.
`timescale 1ns / 1ps
package psaf_pkg;

   localparam int PARTICLE_COUNT = 256;
   localparam int MAX_ATLAS_ROWS = 16;
   localparam int IDX_W          = $clog2(PARTICLE_COUNT);
   localparam logic [4:0] ROWS_RESET = 5'd4;

   localparam logic OP_SPAWN = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [7:0]         particle_index;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [15:0] gravity_factor;
      logic [23:0]        life_span;
      logic [15:0]        time_step;
   } req_type;

   typedef struct packed {
      logic               alive;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        camera_distance;
      logic [7:0]         frame_now;
      logic [7:0]         frame_next;
      logic [15:0]        blend;
      logic [15:0]        offset_now_x;
      logic [15:0]        offset_now_y;
      logic [15:0]        offset_next_x;
      logic [15:0]        offset_next_y;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [15:0] gravity;
      logic [23:0]        lifetime;
      logic [23:0]        elapsed;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD,
      ST_MG, ST_AG, ST_MX, ST_AX, ST_MY, ST_AY, ST_MZ, ST_AZ,
      ST_SD, ST_SL, ST_SLA, ST_SH, ST_SHA, ST_WR, ST_SQ,
      ST_MN, ST_AN, ST_DF, ST_DR, ST_DC1, ST_DR1, ST_DC2, ST_DR2, ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [33:0] b);
      logic signed [34:0] s;
      s = 35'(a) + 35'(b);
      if (s > 35'sd2147483647)
         return 32'sh7FFFFFFF;
      else if (s < -35'sd2147483648)
         return 32'sh80000000;
      else
         return s[31:0];
   endfunction

endpackage

// ----- src/particle_step_with_atlas_frame.sv -----
// Particle table with Euler step, camera distance and atlas frame selection.
// Request paths: tick, tick with saturated distance (square root skipped), spawn,
// and tick to an unspawned entry (zeroed response); one request at a time, busy meanwhile.
// Cost is set by one shared 33x17 multiplier, a 32-step square root and a
// restoring divider (48 steps frame, 8 steps row/column, 4 x 16 steps offsets).
// Synchronous reset clears the valid bits, sets atlas rows to 4 and idles.
`timescale 1ns / 1ps
module particle_step_with_atlas_frame (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  psaf_pkg::req_type req_data,
   output logic              rsp_valid,
   output psaf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_data
);
   import psaf_pkg::*;

   state_type state_ff, state_in;

   entry_type mem [PARTICLE_COUNT];
   entry_type rd_ff;
   logic [PARTICLE_COUNT-1:0] valid_ff;
   logic [4:0] rows_ff;

   logic               op_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [15:0]        dt_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff, vx_ff, vy_ff, vz_ff;
   logic signed [15:0] g_ff;
   logic [23:0]        life_ff, el_ff;
   logic               zero_ff;

   logic signed [32:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [49:0] prod_ff;

   logic [1:0]  axis_ff;
   logic [31:0] mag_ff;
   logic [65:0] acc_ff;
   logic [63:0] sq_x_ff, sq_res_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] dist_ff;

   logic [24:0] dv_rem_ff;
   logic [47:0] dv_num_ff, dv_q_ff;
   logic [23:0] dv_den_ff;
   logic [5:0]  dv_cnt_ff;

   logic [7:0]  f1_ff, f2_ff;
   logic [15:0] blend_ff;
   logic [3:0]  col1_ff, row1_ff, col2_ff, row2_ff;
   logic [15:0] oc1_ff, or1_ff, oc2_ff, or2_ff;

   logic [4:0]  rows_eff;
   logic [8:0]  stages;
   logic [8:0]  smax;
   logic signed [32:0] g50;
   logic signed [32:0] cdiff;
   logic [31:0] cmag;
   logic [63:0] sq_bit, sq_t, sq_res_nx;
   logic        sq_ge;
   logic [25:0] dv_r;
   logic        dv_ge;
   logic [24:0] dv_rem_nx;
   logic [47:0] dv_q_nx;
   logic [31:0] q32;
   logic [7:0]  f1_c, f2_c;
   logic [3:0]  row1_c, col1_c, row2_c, col2_c;
   logic        accept;
   entry_type   wr_rec;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      if (rows_ff == 5'd0) begin
         rows_eff = 5'd1;
      end else if (rows_ff > 5'(MAX_ATLAS_ROWS)) begin
         rows_eff = 5'(MAX_ATLAS_ROWS);
      end else begin
         rows_eff = rows_ff;
      end
      stages = 9'(rows_eff * rows_eff);
      smax   = stages - 9'd1;
   end

   assign g50 = -((33'(g_ff) <<< 5) + (33'(g_ff) <<< 4) + (33'(g_ff) <<< 1));

   always_comb begin
      case (axis_ff)
         2'd0:    cdiff = 33'(cx_ff) - 33'(px_ff);
         2'd1:    cdiff = 33'(cy_ff) - 33'(py_ff);
         default: cdiff = 33'(cz_ff) - 33'(pz_ff);
      endcase
      cmag = cdiff[32] ? 32'(-cdiff) : cdiff[31:0];
   end

   always_comb begin
      case (state_ff)
         ST_MG: begin
            mul_a = g50;
            mul_b = {1'b0, dt_ff};
         end
         ST_MX: begin
            mul_a = 33'(vx_ff);
            mul_b = {1'b0, dt_ff};
         end
         ST_MY: begin
            mul_a = 33'(vy_ff);
            mul_b = {1'b0, dt_ff};
         end
         ST_MZ: begin
            mul_a = 33'(vz_ff);
            mul_b = {1'b0, dt_ff};
         end
         ST_SL: begin
            mul_a = {1'b0, mag_ff};
            mul_b = {1'b0, mag_ff[15:0]};
         end
         ST_SH: begin
            mul_a = {1'b0, mag_ff};
            mul_b = {1'b0, mag_ff[31:16]};
         end
         default: begin
            mul_a = {9'd0, el_ff};
            mul_b = {8'd0, stages};
         end
      endcase
   end

   always_comb begin
      sq_bit    = 64'd1 << {cnt_ff, 1'b0};
      sq_t      = sq_res_ff + sq_bit;
      sq_ge     = sq_x_ff >= sq_t;
      sq_res_nx = sq_ge ? ((sq_res_ff >> 1) + sq_bit) : (sq_res_ff >> 1);
   end

   always_comb begin
      dv_r      = {dv_rem_ff, dv_num_ff[47]};
      dv_ge     = dv_r >= {2'b0, dv_den_ff};
      dv_rem_nx = dv_ge ? 25'(dv_r - {2'b0, dv_den_ff}) : dv_r[24:0];
      dv_q_nx   = {dv_q_ff[46:0], dv_ge};
   end

   always_comb begin
      q32 = dv_q_nx[47:16];
      if (life_ff == 24'd0 || q32 >= 32'(smax)) begin
         f1_c = smax[7:0];
      end else begin
         f1_c = q32[7:0];
      end
      f2_c = (9'(f1_c) != smax) ? f1_c + 8'd1 : f1_c;
   end

   always_comb begin
      row1_c = dv_q_nx[3:0];
      col1_c = dv_rem_nx[3:0];
      if (f2_ff == f1_ff) begin
         col2_c = col1_c;
         row2_c = row1_c;
      end else if (5'(col1_c) + 5'd1 == rows_eff) begin
         col2_c = 4'd0;
         row2_c = row1_c + 4'd1;
      end else begin
         col2_c = col1_c + 4'd1;
         row2_c = row1_c;
      end
   end

   always_comb begin
      wr_rec.pos_x    = px_ff;
      wr_rec.pos_y    = py_ff;
      wr_rec.pos_z    = pz_ff;
      wr_rec.vel_x    = vx_ff;
      wr_rec.vel_y    = vy_ff;
      wr_rec.vel_z    = vz_ff;
      wr_rec.gravity  = g_ff;
      wr_rec.lifetime = life_ff;
      wr_rec.elapsed  = el_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (op_ff == OP_SPAWN) begin
               state_in = ST_MN;
            end else if (!valid_ff[idx_ff]) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MG;
            end
         end
         ST_MG:  state_in = ST_AG;
         ST_AG:  state_in = ST_MX;
         ST_MX:  state_in = ST_AX;
         ST_AX:  state_in = ST_MY;
         ST_MY:  state_in = ST_AY;
         ST_AY:  state_in = ST_MZ;
         ST_MZ:  state_in = ST_AZ;
         ST_AZ:  state_in = ST_SD;
         ST_SD:  state_in = ST_SL;
         ST_SL:  state_in = ST_SLA;
         ST_SLA: state_in = ST_SH;
         ST_SH:  state_in = ST_SHA;
         ST_SHA: state_in = (axis_ff == 2'd2) ? ST_WR : ST_SD;
         ST_WR:  state_in = (acc_ff[65:64] == 2'd0) ? ST_SQ : ST_MN;
         ST_SQ:  state_in = (cnt_ff == 5'd0) ? ST_MN : ST_SQ;
         ST_MN:  state_in = ST_AN;
         ST_AN:  state_in = ST_DF;
         ST_DF:  state_in = (dv_cnt_ff == 6'd0) ? ST_DR : ST_DF;
         ST_DR:  state_in = (dv_cnt_ff == 6'd0) ? ST_DC1 : ST_DR;
         ST_DC1: state_in = (dv_cnt_ff == 6'd0) ? ST_DR1 : ST_DC1;
         ST_DR1: state_in = (dv_cnt_ff == 6'd0) ? ST_DC2 : ST_DR1;
         ST_DC2: state_in = (dv_cnt_ff == 6'd0) ? ST_DR2 : ST_DC2;
         ST_DR2: state_in = (dv_cnt_ff == 6'd0) ? ST_OUT : ST_DR2;
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      rsp_data.alive           = el_ff < life_ff;
      rsp_data.pos_x           = px_ff;
      rsp_data.pos_y           = py_ff;
      rsp_data.pos_z           = pz_ff;
      rsp_data.camera_distance = dist_ff;
      rsp_data.frame_now       = f1_ff;
      rsp_data.frame_next      = f2_ff;
      rsp_data.blend           = blend_ff;
      rsp_data.offset_now_x    = oc1_ff;
      rsp_data.offset_now_y    = or1_ff;
      rsp_data.offset_next_x   = oc2_ff;
      rsp_data.offset_next_y   = or2_ff;
      if (zero_ff) rsp_data = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rows_ff  <= ROWS_RESET;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) rows_ff <= csr_data;
         if (accept) zero_ff <= 1'b0;
         if (state_ff == ST_LOAD) begin
            if (op_ff == OP_SPAWN) begin
               valid_ff[idx_ff] <= 1'b1;
            end else if (!valid_ff[idx_ff]) begin
               zero_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rd_ff <= mem[req_data.particle_index];
      if (state_ff == ST_WR) mem[idx_ff] <= wr_rec;
      if (state_ff == ST_LOAD && op_ff == OP_SPAWN) begin
         mem[idx_ff] <= '{pos_x: cx_ff, pos_y: cy_ff, pos_z: cz_ff,
                          vel_x: vx_ff, vel_y: vy_ff, vel_z: vz_ff,
                          gravity: g_ff, lifetime: life_ff, elapsed: 24'd0};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_ff   <= req_data.operation;
               idx_ff  <= req_data.particle_index;
               dt_ff   <= req_data.time_step;
               cx_ff   <= req_data.vec_x;
               cy_ff   <= req_data.vec_y;
               cz_ff   <= req_data.vec_z;
               vx_ff   <= req_data.vel_x;
               vy_ff   <= req_data.vel_y;
               vz_ff   <= req_data.vel_z;
               g_ff    <= req_data.gravity_factor;
               life_ff <= req_data.life_span;
            end
         end
         ST_LOAD: begin
            if (op_ff == OP_SPAWN) begin
               px_ff   <= cx_ff;
               py_ff   <= cy_ff;
               pz_ff   <= cz_ff;
               el_ff   <= 24'd0;
               dist_ff <= 32'd0;
            end else begin
               px_ff   <= rd_ff.pos_x;
               py_ff   <= rd_ff.pos_y;
               pz_ff   <= rd_ff.pos_z;
               vx_ff   <= rd_ff.vel_x;
               vy_ff   <= rd_ff.vel_y;
               vz_ff   <= rd_ff.vel_z;
               g_ff    <= rd_ff.gravity;
               life_ff <= rd_ff.lifetime;
               el_ff   <= rd_ff.elapsed;
            end
         end
         ST_AG: vy_ff <= sat_add(vy_ff, prod_ff[41:8]);
         ST_AX: px_ff <= sat_add(px_ff, prod_ff[49:16]);
         ST_AY: py_ff <= sat_add(py_ff, prod_ff[49:16]);
         ST_AZ: begin
            pz_ff   <= sat_add(pz_ff, prod_ff[49:16]);
            el_ff   <= ((25'(el_ff) + 25'(dt_ff)) > 25'h0FFFFFF) ? 24'hFFFFFF
                       : el_ff + 24'(dt_ff);
            acc_ff  <= '0;
            axis_ff <= 2'd0;
         end
         ST_SD:  mag_ff <= cmag;
         ST_SLA: acc_ff <= acc_ff + 66'(prod_ff[47:0]);
         ST_SHA: begin
            acc_ff  <= acc_ff + (66'(prod_ff[47:0]) << 16);
            axis_ff <= axis_ff + 2'd1;
         end
         ST_WR: begin
            sq_x_ff   <= acc_ff[63:0];
            sq_res_ff <= '0;
            cnt_ff    <= 5'd31;
            dist_ff   <= 32'hFFFFFFFF;
         end
         ST_SQ: begin
            if (sq_ge) sq_x_ff <= sq_x_ff - sq_t;
            sq_res_ff <= sq_res_nx;
            cnt_ff    <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) dist_ff <= sq_res_nx[31:0];
         end
         ST_AN: begin
            dv_rem_ff <= '0;
            dv_num_ff <= {prod_ff[31:0], 16'd0};
            dv_q_ff   <= '0;
            dv_den_ff <= life_ff;
            dv_cnt_ff <= 6'd47;
         end
         ST_DF, ST_DR, ST_DC1, ST_DR1, ST_DC2, ST_DR2: begin
            dv_rem_ff <= dv_rem_nx;
            dv_num_ff <= {dv_num_ff[46:0], 1'b0};
            dv_q_ff   <= dv_q_nx;
            dv_cnt_ff <= dv_cnt_ff - 6'd1;
            if (dv_cnt_ff == 6'd0) begin
               dv_q_ff   <= '0;
               dv_den_ff <= {19'd0, rows_eff};
               dv_num_ff <= '0;
               dv_cnt_ff <= 6'd15;
               case (state_ff)
                  ST_DF: begin
                     f1_ff     <= f1_c;
                     f2_ff     <= f2_c;
                     blend_ff  <= (life_ff == 24'd0) ? 16'd0 : dv_q_nx[15:0];
                     dv_rem_ff <= '0;
                     dv_num_ff <= {f1_c, 40'd0};
                     dv_cnt_ff <= 6'd7;
                  end
                  ST_DR: begin
                     row1_ff   <= row1_c;
                     col1_ff   <= col1_c;
                     row2_ff   <= row2_c;
                     col2_ff   <= col2_c;
                     dv_rem_ff <= 25'(col1_c);
                  end
                  ST_DC1: begin
                     oc1_ff    <= dv_q_nx[15:0];
                     dv_rem_ff <= 25'(row1_ff);
                  end
                  ST_DR1: begin
                     or1_ff    <= dv_q_nx[15:0];
                     dv_rem_ff <= 25'(col2_ff);
                  end
                  ST_DC2: begin
                     oc2_ff    <= dv_q_nx[15:0];
                     dv_rem_ff <= 25'(row2_ff);
                  end
                  default: begin
                     or2_ff    <= dv_q_nx[15:0];
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

endmodule
